FILE: src/block_table_heap_allocator_macros.svh
// assertion macros for the block table heap allocator
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_MACROS_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define BTH_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");
// next-cycle implication, sampled on clk, off during reset
`define BTH_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define BTH_ASSERT_IMP(lbl, pre, post)
`define BTH_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: src/bth_pkg.sv
// shared constants, types and controller/datapath bundles for the allocator
`default_nettype none

package bth_pkg;

    // both sizes are powers of two
    localparam int TABLE_DEPTH = 1024;
    localparam int BLOCK_BYTES = 4096;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int ADDR_W = 32;
    localparam int PAGE_W = ADDR_W - OFF_W;
    localparam int NEED_W = PAGE_W + 1;
    localparam int BIU_W  = 11;
    localparam int LIM_W  = (CNT_W > BIU_W) ? CNT_W : BIU_W;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 1;
    localparam int STAT_W     = 2;
    localparam int OUT_DATA_W = 40;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'h0100_0000;
    localparam logic [BIU_W-1:0]  BLOCKS_RST    = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_BLOCKS    = 1'b1;

    typedef enum logic [1:0] {
        RES_OK_ALLOC,
        RES_OK_FREE,
        RES_NOMEM,
        RES_RANGE
    } res_kind_t;

    typedef struct packed {
        logic has_next;
        logic first;
        logic taken;
    } entry_t;

    typedef struct packed {
        logic      load_item;
        logic      clear_en;
        logic      scan_start;
        logic      scan_en;
        logic      mark_en;
        logic      free_start;
        logic      free_wr;
        logic      res_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic alloc_bad;
        logic free_bad;
        logic scan_hit;
        logic scan_miss;
        logic mark_last;
        logic free_more;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/block_table_heap_allocator.sv
// first-fit block table heap allocator: top level with apb registers and output register
//
// Command items enter on the s_ channel: tuser[0] picks allocate (0) or free (1),
// tdata carries the byte count and the address to free. Each item gives exactly
// one result item on the m_ channel: status and granted address.
// One item is worked on at a time. An allocate runs a first-fit scan over the table
// entries, read one a cycle from the block table memory, then marks the blocks of
// the run found, one write a cycle; when no run fits, the result is no-memory. A
// free walks its chain entries, reading and then clearing each; a rejected command
// gets its result straight from the check. The next item can be taken in the cycle
// after the hand-off. After reset the table memory is cleared one entry a cycle,
// and s_tready stays low meanwhile; apb writes are taken at any time.
// Results sit in an output register; while the receiver stalls, the next command
// can be accepted and worked on, and its result waits inside until the register
// is taken. Registers: 0x0 heap base (block aligned, low bits ignored),
// 0x4 blocks in use. Reconfigure only while no command is outstanding.
`default_nettype none

`include "block_table_heap_allocator_macros.svh"

module block_table_heap_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bth_pkg::IN_DATA_W-1:0]  s_tdata,   // request_bytes[31:0], free_address[63:32]
    input  logic [bth_pkg::IN_USER_W-1:0]  s_tuser,   // command[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bth_pkg::OUT_DATA_W-1:0] m_tdata,   // status[1:0], granted_address[33:2]
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bth_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bth_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bth_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bth_pkg::*;

    logic [ADDR_W-1:0]     heap_base_reg;
    logic [BIU_W-1:0]      blocks_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  cfg_wr;
    logic                  out_free;
    logic                  deliver;
    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [STAT_W-1:0]     res_status;
    logic [ADDR_W-1:0]     res_granted_address;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= HEAP_BASE_RST;
            blocks_reg    <= BLOCKS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_HEAP_BASE: heap_base_reg <= pwdata;
                REG_BLOCKS:    blocks_reg    <= pwdata[BIU_W-1:0];
                default:       heap_base_reg <= heap_base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HEAP_BASE: prdata = heap_base_reg;
            REG_BLOCKS:    prdata = {{(APB_DATA_W-BIU_W){1'b0}}, blocks_reg};
            default:       prdata = '0;
        endcase
    end

    bth_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .out_free   (out_free),
        .deliver    (deliver),
        .cmd        (cmd),
        .stat       (stat)
    );

    bth_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .item_command        (s_tuser[0]),
        .item_request_bytes  (s_tdata[ADDR_W-1:0]),
        .item_free_address   (s_tdata[2*ADDR_W-1:ADDR_W]),
        .heap_base           (heap_base_reg),
        .blocks_in_use       (blocks_reg),
        .res_status          (res_status),
        .res_granted_address (res_granted_address)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (deliver)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
            m_tdata_reg <= {{(OUT_DATA_W-STAT_W-ADDR_W){1'b0}}, res_granted_address, res_status};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one command in flight: no accept right after an accept
    `BTH_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // a result only appears through a hand-off from the controller
    `BTH_ASSERT_IMP(a_rise_from_deliver, $rose(m_tvalid_reg), $past(deliver))
    // granted addresses are always block aligned
    `BTH_ASSERT_IMP(a_addr_aligned, m_tvalid_reg, m_tdata_reg[STAT_W+OFF_W-1:STAT_W] == '0)
    // only defined status codes leave the block
    `BTH_ASSERT_IMP(a_status_code, m_tvalid_reg, m_tdata_reg[STAT_W-1:0] <= STAT_RANGE)

endmodule

`default_nettype wire

FILE: src/bth_datapath.sv
// block table memory, scan/mark/free counters, address math and result register
`default_nettype none

module bth_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bth_pkg::dp_cmd_t           cmd,
    output bth_pkg::dp_stat_t          stat,
    input  logic                       item_command,
    input  logic [bth_pkg::ADDR_W-1:0] item_request_bytes,
    input  logic [bth_pkg::ADDR_W-1:0] item_free_address,
    input  logic [bth_pkg::ADDR_W-1:0] heap_base,
    input  logic [bth_pkg::BIU_W-1:0]  blocks_in_use,
    output logic [bth_pkg::STAT_W-1:0] res_status,
    output logic [bth_pkg::ADDR_W-1:0] res_granted_address
);
    import bth_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic   wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    logic              command_reg;
    logic [ADDR_W-1:0] bytes_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [CNT_W-1:0] p_reg, p_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             q_valid_reg, q_valid_next;
    logic [IDX_W-1:0] q_idx_reg, q_idx_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0] f_reg, f_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    logic [STAT_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0] gaddr_reg, gaddr_next;

    logic [LIM_W-1:0]  biu_ext;
    logic [CNT_W-1:0]  used_n;
    logic [CNT_W-1:0]  need_c;
    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] used_ext;
    logic [NEED_W-1:0] fidx_ext;
    logic [PAGE_W-1:0] base_page;
    logic [PAGE_W-1:0] addr_page;
    logic [PAGE_W-1:0] fidx;
    logic              issue;
    logic              proc;

    // blocks actually covered, capped at the table depth
    assign biu_ext  = LIM_W'(blocks_in_use);
    assign used_n   = (biu_ext < LIM_W'(TABLE_DEPTH)) ? CNT_W'(biu_ext) : CNT_W'(TABLE_DEPTH);
    assign used_ext = NEED_W'(used_n);

    // round the byte count up to whole blocks
    assign need   = {1'b0, bytes_reg[ADDR_W-1:OFF_W]} + NEED_W'(|bytes_reg[OFF_W-1:0]);
    assign need_c = need[CNT_W-1:0];

    assign base_page = heap_base[ADDR_W-1:OFF_W];
    assign addr_page = addr_reg[ADDR_W-1:OFF_W];
    assign fidx      = addr_page - base_page;
    assign fidx_ext  = {1'b0, fidx};

    assign issue = cmd.scan_en && (p_reg < used_n);
    assign proc  = cmd.scan_en && q_valid_reg;

    always_comb
    begin
        stat.clear_last = (clr_reg == IDX_W'(TABLE_DEPTH - 1));
        stat.is_free    = (command_reg == CMD_FREE);
        stat.alloc_bad  = (bytes_reg == '0) || (need > used_ext);
        stat.free_bad   = (addr_page < base_page) || (fidx_ext >= used_ext);
        stat.scan_hit   = proc && !rd_data_reg.taken && ((run_reg + CNT_W'(1)) == need_c);
        // pipeline drained with every covered entry looked at
        stat.scan_miss  = cmd.scan_en && !q_valid_reg && (p_reg == used_n);
        stat.mark_last  = ((k_reg + CNT_W'(1)) == need_c);
        stat.free_more  = rd_data_reg.has_next && ((CNT_W'(f_reg) + CNT_W'(1)) < used_n);
    end

    assign rd_addr = cmd.scan_en ? p_reg[IDX_W-1:0] : f_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        priority if (cmd.clear_en)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.mark_en)
        begin
            wr_en            = 1'b1;
            wr_addr          = start_reg + k_reg[IDX_W-1:0];
            wr_data.taken    = 1'b1;
            wr_data.first    = (k_reg == '0);
            wr_data.has_next = ((k_reg + CNT_W'(1)) != need_c);
        end
        else if (cmd.free_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = f_reg;
        end
    end

    always_comb
    begin
        p_next       = p_reg;
        q_valid_next = 1'b0;
        q_idx_next   = p_reg[IDX_W-1:0];
        run_next     = run_reg;
        start_next   = start_reg;
        k_next       = k_reg;
        f_next       = f_reg;
        clr_next     = clr_reg;
        status_next  = status_reg;
        gaddr_next   = gaddr_reg;

        if (cmd.clear_en)
            clr_next = clr_reg + IDX_W'(1);

        if (cmd.scan_start)
        begin
            p_next   = '0;
            run_next = '0;
            k_next   = '0;
        end

        if (issue)
        begin
            p_next       = p_reg + CNT_W'(1);
            q_valid_next = 1'b1;
        end

        if (proc)
        begin
            if (rd_data_reg.taken)
                run_next = '0;
            else
            begin
                if (run_reg == '0)
                    start_next = q_idx_reg;
                run_next = run_reg + CNT_W'(1);
            end
        end

        if (cmd.mark_en)
            k_next = k_reg + CNT_W'(1);

        if (cmd.free_start)
            f_next = fidx[IDX_W-1:0];
        else if (cmd.free_wr && stat.free_more)
            f_next = f_reg + IDX_W'(1);

        if (cmd.res_load)
        begin
            unique case (cmd.res_kind)
                RES_OK_ALLOC:
                begin
                    status_next = STAT_OK;
                    gaddr_next  = {base_page + PAGE_W'(start_reg), {OFF_W{1'b0}}};
                end
                RES_OK_FREE:
                begin
                    status_next = STAT_OK;
                    gaddr_next  = '0;
                end
                RES_NOMEM:
                begin
                    status_next = STAT_NOMEM;
                    gaddr_next  = '0;
                end
                RES_RANGE:
                begin
                    status_next = STAT_RANGE;
                    gaddr_next  = '0;
                end
                default:
                begin
                    status_next = STAT_NOMEM;
                    gaddr_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            clr_reg     <= '0;
        end
        else
        begin
            q_valid_reg <= cmd.scan_start ? 1'b0 : q_valid_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            command_reg <= item_command;
            bytes_reg   <= item_request_bytes;
            addr_reg    <= item_free_address;
        end
        p_reg      <= p_next;
        q_idx_reg  <= q_idx_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        k_reg      <= k_next;
        f_reg      <= f_next;
        status_reg <= status_next;
        gaddr_reg  <= gaddr_next;
    end

    assign res_status          = status_reg;
    assign res_granted_address = gaddr_reg;

endmodule

`default_nettype wire

FILE: src/bth_ctrl.sv
// sequencing state machine: clear pass, check, scan, mark, free walk, hand-off
`default_nettype none

module bth_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              out_free,
    output logic              deliver,
    output bth_pkg::dp_cmd_t  cmd,
    input  bth_pkg::dp_stat_t stat
);
    import bth_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_FRD   = 7'b0100000,
        S_FWR   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.res_kind = RES_NOMEM;
        item_ready = 1'b0;
        deliver    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                // a finished result waits here until the output slot frees
                if (done_reg)
                begin
                    if (out_free)
                    begin
                        deliver   = 1'b1;
                        done_next = 1'b0;
                    end
                end
                else
                begin
                    item_ready = 1'b1;
                    if (item_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!stat.is_free)
                begin
                    if (stat.alloc_bad)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_NOMEM;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else if (stat.free_bad)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_RANGE;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.free_start = 1'b1;
                    state_next     = S_FRD;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_hit)
                    state_next = S_MARK;
                else if (stat.scan_miss)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_NOMEM;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MARK:
            begin
                cmd.mark_en = 1'b1;
                if (stat.mark_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_OK_ALLOC;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FRD:
            begin
                state_next = S_FWR;
            end
            S_FWR:
            begin
                cmd.free_wr = 1'b1;
                if (stat.free_more)
                    state_next = S_FRD;
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_OK_FREE;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                done_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire
